// ===== rtl/core/wss_pkg.sv =====
// Shared types and constants for the WAVE sample to stereo 16-bit converter.
// Used by every module in rtl/core; depends on nothing.
`timescale 1ns / 1ps

package wss_pkg;

	localparam int unsigned POSITION_BITS_DEFAULT = 32;
	localparam int unsigned CFG_DATA_BITS = 32;
	localparam int unsigned CFG_INDEX_BITS = 2;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_SAMPLE_FORMAT = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CHANNEL_COUNT = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAMES_IN_DATA = 2'd2;

	localparam logic [2:0] FMT_PCM8 = 3'd0;
	localparam logic [2:0] FMT_PCM16 = 3'd1;
	localparam logic [2:0] FMT_PCM24 = 3'd2;
	localparam logic [2:0] FMT_PCM32 = 3'd3;
	localparam logic [2:0] FMT_FLOAT32 = 3'd4;

	localparam logic [1:0] CHANNELS_MONO = 2'd1;
	localparam logic [1:0] CHANNELS_STEREO = 2'd2;

	localparam logic [2:0] SAMPLE_FORMAT_RESET = FMT_PCM16;
	localparam logic [1:0] CHANNEL_COUNT_RESET = CHANNELS_STEREO;
	localparam logic [31:0] FRAMES_IN_DATA_RESET = 32'd1;

	localparam logic [7:0] PCM8_BIAS = 8'd128;
	localparam logic [14:0] FLOAT_SCALE = 15'd32767;
	localparam logic [15:0] S16_MAX = 16'h7FFF;
	localparam logic [15:0] S16_MIN = 16'h8000;

	typedef struct packed {
		logic [2:0] sample_format;
		logic [1:0] channel_count;
		logic [31:0] frames_in_data;
	} cfg_t;

endpackage

// ===== rtl/core/wss_byte_if.sv =====
// Byte channel: valid/ready handshake carrying one WAVE data byte per item.
// No dependencies.
`timescale 1ns / 1ps

interface wss_byte_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;

	modport source(output valid, output data_byte, input ready);
	modport sink(input valid, input data_byte, output ready);
endinterface

// ===== rtl/core/wss_frame_if.sv =====
// Frame channel: valid/ready handshake carrying one stereo 16-bit frame per item.
// No dependencies.
`timescale 1ns / 1ps

interface wss_frame_if;
	logic valid;
	logic ready;
	logic signed [15:0] left_sample;
	logic signed [15:0] right_sample;
	logic [31:0] next_position;
	logic wrapped;
	logic looped_sticky;

	modport source(output valid, output left_sample, output right_sample,
		output next_position, output wrapped, output looped_sticky, input ready);
	modport sink(input valid, input left_sample, input right_sample,
		input next_position, input wrapped, input looped_sticky, output ready);
endinterface

// ===== rtl/core/wss_gather.sv =====
// Byte gather stage: assembles little-endian sample words, registers each word.
// Depends on wss_pkg and wss_byte_if.
`timescale 1ns / 1ps

module wss_gather (
	input logic clk,
	input logic arst_n,
	input wss_pkg::cfg_t cfg,
	wss_byte_if.sink data,
	input logic word_take,
	output logic word_valid_s1,
	output logic [31:0] word_s1
);

	logic [23:0] gather_q;
	logic [1:0] count_q;
	logic [1:0] last;
	logic accept;
	logic complete;
	logic [31:0] word_next;
	logic [23:0] gather_next;

	always_comb begin
		case (cfg.sample_format)
			wss_pkg::FMT_PCM8: last = 2'd0;
			wss_pkg::FMT_PCM24: last = 2'd2;
			wss_pkg::FMT_PCM32: last = 2'd3;
			wss_pkg::FMT_FLOAT32: last = 2'd3;
			default: last = 2'd1;
		endcase
	end

	assign data.ready = !word_valid_s1 || word_take;
	assign accept = data.valid && data.ready;
	assign complete = (count_q >= last);
	assign gather_next = gather_q | ({16'h0000, data.data_byte} << {count_q, 3'b000});

	always_comb begin
		case (last)
			2'd0: word_next = {24'h000000, data.data_byte};
			2'd1: word_next = {16'h0000, data.data_byte, gather_q[7:0]};
			2'd2: word_next = {8'h00, data.data_byte, gather_q[15:0]};
			default: word_next = {data.data_byte, gather_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gather_q <= '0;
			count_q <= '0;
			word_valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (complete) begin
					gather_q <= '0;
					count_q <= '0;
				end else begin
					gather_q <= gather_next;
					count_q <= count_q + 2'd1;
				end
			end
			if (accept && complete) begin
				word_valid_s1 <= 1'b1;
			end else if (word_take) begin
				word_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && complete) begin
			word_s1 <= word_next;
		end
	end

endmodule

// ===== rtl/core/wss_convert.sv =====
// Conversion stage: turns a gathered sample word into signed 16 bits.
// Depends on wss_pkg.
`timescale 1ns / 1ps

module wss_convert (
	input logic clk,
	input logic arst_n,
	input wss_pkg::cfg_t cfg,
	input logic word_valid_s1,
	input logic [31:0] word_s1,
	output logic word_take,
	input logic sample_take,
	output logic sample_valid_s2,
	output logic [15:0] sample_s2
);

	logic [15:0] sample_next;

	function automatic logic [15:0] float_to_s16(input logic [31:0] w);
		logic neg;
		logic [7:0] e;
		logic [22:0] m;
		logic [7:0] sh;
		logic [38:0] p;
		logic [38:0] mag;
		logic [15:0] res;
		neg = w[31];
		e = w[30:23];
		m = w[22:0];
		sh = 8'd150 - e;
		p = 39'({1'b1, m}) * 39'(wss_pkg::FLOAT_SCALE);
		mag = p >> sh;
		if (e == 8'hFF) begin
			if (m != '0) begin
				res = '0;
			end else begin
				res = neg ? wss_pkg::S16_MIN : wss_pkg::S16_MAX;
			end
		end else if (e == 8'h00) begin
			res = '0;
		end else if (e >= 8'd150) begin
			res = neg ? wss_pkg::S16_MIN : wss_pkg::S16_MAX;
		end else if (neg) begin
			res = (mag >= 39'd32768) ? wss_pkg::S16_MIN : 16'(-mag[15:0]);
		end else begin
			res = (mag > 39'd32767) ? wss_pkg::S16_MAX : mag[15:0];
		end
		return res;
	endfunction

	always_comb begin
		case (cfg.sample_format)
			wss_pkg::FMT_PCM8: sample_next = {word_s1[7:0] ^ wss_pkg::PCM8_BIAS, 8'h00};
			wss_pkg::FMT_PCM24: sample_next = word_s1[23:8];
			wss_pkg::FMT_PCM32: sample_next = word_s1[31:16];
			wss_pkg::FMT_FLOAT32: sample_next = float_to_s16(word_s1);
			default: sample_next = word_s1[15:0];
		endcase
	end

	assign word_take = word_valid_s1 && (!sample_valid_s2 || sample_take);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid_s2 <= 1'b0;
		end else if (word_take) begin
			sample_valid_s2 <= 1'b1;
		end else if (sample_take) begin
			sample_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (word_take) begin
			sample_s2 <= sample_next;
		end
	end

endmodule

// ===== rtl/core/wss_frame.sv =====
// Frame stage: pairs channels, advances the wrapping frame position, holds the
// result register. Depends on wss_pkg and wss_frame_if.
`timescale 1ns / 1ps

module wss_frame #(
	parameter int unsigned POSITION_BITS = wss_pkg::POSITION_BITS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input wss_pkg::cfg_t cfg,
	input logic sample_valid_s2,
	input logic [15:0] sample_s2,
	output logic sample_take,
	wss_frame_if.source frame
);

	logic slot_q;
	logic [15:0] held_left_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic looped_q;
	logic out_valid_q;
	logic [15:0] left_q;
	logic [15:0] right_q;
	logic [31:0] next_pos_q;
	logic wrapped_q;
	logic looped_out_q;

	logic mono;
	logic emit;
	logic out_free;
	logic emit_take;
	logic [POSITION_BITS:0] pos_inc;
	logic [POSITION_BITS-1:0] next_raw;
	logic wrap;

	assign mono = (cfg.channel_count == wss_pkg::CHANNELS_MONO);
	assign emit = mono || slot_q;
	assign out_free = !out_valid_q || frame.ready;
	assign sample_take = sample_valid_s2 && (!emit || out_free);
	assign emit_take = sample_take && emit;

	assign pos_inc = {1'b0, pos_q} + {{POSITION_BITS{1'b0}}, 1'b1};
	assign next_raw = pos_inc[POSITION_BITS-1:0];
	assign wrap = pos_inc[POSITION_BITS] || (32'(next_raw) >= cfg.frames_in_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= 1'b0;
			held_left_q <= '0;
			pos_q <= '0;
			looped_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (sample_take) begin
				if (mono) begin
					slot_q <= 1'b0;
				end else if (!slot_q) begin
					held_left_q <= sample_s2;
					slot_q <= 1'b1;
				end else begin
					slot_q <= 1'b0;
				end
			end
			if (emit_take) begin
				pos_q <= wrap ? '0 : next_raw;
				looped_q <= looped_q || wrap;
			end
			if (emit_take) begin
				out_valid_q <= 1'b1;
			end else if (frame.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_take) begin
			left_q <= mono ? sample_s2 : held_left_q;
			right_q <= sample_s2;
			next_pos_q <= wrap ? '0 : 32'(next_raw);
			wrapped_q <= wrap;
			looped_out_q <= looped_q || wrap;
		end
	end

	assign frame.valid = out_valid_q;
	assign frame.left_sample = left_q;
	assign frame.right_sample = right_q;
	assign frame.next_position = next_pos_q;
	assign frame.wrapped = wrapped_q;
	assign frame.looped_sticky = looped_out_q;

	a_wrap_zero_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && wrapped_q |-> next_pos_q == '0)
		else $error("wrapped frame with nonzero position");

	a_wrap_sets_looped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && wrapped_q |-> looped_out_q && looped_q)
		else $error("wrap did not set looped flag");

	a_slot_needs_stereo: assert property (@(posedge clk) disable iff (!arst_n)
		sample_take && !slot_q && !mono |=> slot_q)
		else $error("left sample not held");

endmodule

// ===== rtl/core/wave_sample_to_stereo16.sv =====
// Top level of the WAVE sample to stereo 16-bit converter: configuration
// registers and the gather, convert and frame stages.
// Depends on wss_pkg, wss_byte_if, wss_frame_if, wss_gather, wss_convert, wss_frame.
`timescale 1ns / 1ps

// Takes one WAVE data byte per clock while input is not stalled (pcm8, pcm16,
// pcm24, pcm32 or float32, mono or stereo) and emits one signed 16-bit stereo
// frame per completed frame with its wrapping frame position. A byte that
// completes a frame reaches the output through the gather, convert and frame
// registers in that order; these registers each hold one item, so input stalls
// only when all three are full behind an output frame not yet taken.
// Write the configuration registers only while no frame is in flight.

module wave_sample_to_stereo16 #(
	parameter int unsigned POSITION_BITS = wss_pkg::POSITION_BITS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [wss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input logic [wss_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
	wss_byte_if.sink data,
	wss_frame_if.source frame
);

	wss_pkg::cfg_t cfg_q;
	logic word_valid_s1;
	logic [31:0] word_s1;
	logic word_take;
	logic sample_valid_s2;
	logic [15:0] sample_s2;
	logic sample_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_format <= wss_pkg::SAMPLE_FORMAT_RESET;
			cfg_q.channel_count <= wss_pkg::CHANNEL_COUNT_RESET;
			cfg_q.frames_in_data <= wss_pkg::FRAMES_IN_DATA_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				wss_pkg::CFG_SAMPLE_FORMAT: cfg_q.sample_format <= cfg_wdata[2:0];
				wss_pkg::CFG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_wdata[1:0];
				wss_pkg::CFG_FRAMES_IN_DATA: cfg_q.frames_in_data <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	wss_gather u_gather (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.data(data),
		.word_take(word_take),
		.word_valid_s1(word_valid_s1),
		.word_s1(word_s1)
	);

	wss_convert u_convert (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.word_valid_s1(word_valid_s1),
		.word_s1(word_s1),
		.word_take(word_take),
		.sample_take(sample_take),
		.sample_valid_s2(sample_valid_s2),
		.sample_s2(sample_s2)
	);

	wss_frame #(
		.POSITION_BITS(POSITION_BITS)
	) u_frame (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.sample_valid_s2(sample_valid_s2),
		.sample_s2(sample_s2),
		.sample_take(sample_take),
		.frame(frame)
	);

	a_stall_only_on_output: assert property (@(posedge clk) disable iff (!arst_n)
		!data.ready |-> frame.valid && !frame.ready && word_valid_s1 && sample_valid_s2)
		else $error("input stalled without a blocked output");

endmodule

// ===== bench/wss_frame_checker.sv =====
// Frame checker for the WAVE sample to stereo 16-bit converter: shadows the
// configuration writes, predicts each stereo frame from the accepted bytes and
// compares it with the frames taken from the block. Depends on wss_pkg and the
// byte and frame channel interfaces.
`timescale 1ns / 1ps

module wss_frame_checker import wss_pkg::*; #(
	parameter int unsigned POSITION_BITS = POSITION_BITS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [CFG_INDEX_BITS-1:0] cfg_index,
	input logic [CFG_DATA_BITS-1:0] cfg_wdata,
	wss_byte_if byte_bus,
	wss_frame_if frame_bus,
	output int unsigned outstanding,
	output int unsigned fail_count
);

	localparam logic [31:0] POS_MASK = (POSITION_BITS >= 32) ? 32'hFFFF_FFFF
		: ((32'd1 << POSITION_BITS) - 32'd1);

	typedef struct packed {
		logic [15:0] left_sample;
		logic [15:0] right_sample;
		logic [31:0] next_position;
		logic wrapped;
		logic looped_sticky;
	} stereo_frame_t;

	stereo_frame_t expected_frames[$];
	int unsigned frames_seen;

	logic [2:0] fmt_r;
	logic [1:0] chan_r;
	logic [31:0] frames_r;
	logic [23:0] gather;
	logic [1:0] gather_count;
	logic slot;
	logic [15:0] held;
	logic [31:0] position;
	logic looped;

	function automatic logic [1:0] last_byte_index(input logic [2:0] fmt);
		case (fmt)
			FMT_PCM8: return 2'd0;
			FMT_PCM24: return 2'd2;
			FMT_PCM32, FMT_FLOAT32: return 2'd3;
			default: return 2'd1;
		endcase
	endfunction

	function automatic logic [15:0] float_to_pcm16(input logic [31:0] w);
		logic [7:0] e;
		logic [22:0] m;
		logic [63:0] prod;
		logic [63:0] mag;
		e = w[30:23];
		m = w[22:0];
		if (e == 8'hFF) begin
			if (m != '0)
				return 16'h0000;
			return w[31] ? S16_MIN : S16_MAX;
		end
		if (e == 8'h00)
			return 16'h0000;
		if (e >= 8'd150) begin
			mag = 64'h10000;
		end else begin
			prod = {40'd0, 1'b1, m} * 64'(FLOAT_SCALE);
			mag = prod >> (8'd150 - e);
		end
		if (w[31]) begin
			if (mag >= 64'd32768)
				return S16_MIN;
			return ~mag[15:0] + 16'd1;
		end
		if (mag > 64'd32767)
			return S16_MAX;
		return mag[15:0];
	endfunction

	function automatic logic [15:0] sample_to_pcm16(input logic [2:0] fmt, input logic [31:0] word);
		case (fmt)
			FMT_PCM8: return {word[7:0] ^ PCM8_BIAS, 8'h00};
			FMT_PCM24: return word[23:8];
			FMT_PCM32: return word[31:16];
			FMT_FLOAT32: return float_to_pcm16(word);
			default: return word[15:0];
		endcase
	endfunction

	task automatic report(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		fail_count++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report($sformatf("frame %0d %s: got %0h, expected %0h", frames_seen, name,
				got, want));
	endtask

	task automatic absorb_byte(input logic [7:0] b);
		logic [1:0] last;
		logic [31:0] word;
		logic [31:0] nxt;
		logic [15:0] sample;
		stereo_frame_t f;
		last = last_byte_index(fmt_r);
		if (gather_count < last) begin
			gather = gather | (24'(b) << (8 * gather_count));
			gather_count = gather_count + 2'd1;
			return;
		end
		case (last)
			2'd0: word = {24'd0, b};
			2'd1: word = {16'd0, b, gather[7:0]};
			2'd2: word = {8'd0, b, gather[15:0]};
			default: word = {b, gather};
		endcase
		gather = '0;
		gather_count = '0;
		sample = sample_to_pcm16(fmt_r, word);
		if (chan_r == CHANNELS_MONO) begin
			slot = 1'b0;
			f.left_sample = sample;
			f.right_sample = sample;
		end else if (!slot) begin
			held = sample;
			slot = 1'b1;
			return;
		end else begin
			slot = 1'b0;
			f.left_sample = held;
			f.right_sample = sample;
		end
		nxt = (position + 32'd1) & POS_MASK;
		f.wrapped = (nxt == '0) || (nxt >= frames_r);
		if (f.wrapped) begin
			nxt = '0;
			looped = 1'b1;
		end
		position = nxt;
		f.next_position = nxt;
		f.looped_sticky = looped;
		expected_frames.push_back(f);
	endtask

	task automatic check_frame();
		stereo_frame_t want;
		if (expected_frames.size() == 0) begin
			report($sformatf("frame %0d arrived with no frame expected", frames_seen));
			frames_seen++;
			return;
		end
		want = expected_frames.pop_front();
		compare_field("left_sample", {16'd0, frame_bus.left_sample}, want.left_sample);
		compare_field("right_sample", {16'd0, frame_bus.right_sample}, want.right_sample);
		compare_field("next_position", frame_bus.next_position, want.next_position);
		compare_field("wrapped", frame_bus.wrapped, want.wrapped);
		compare_field("looped_sticky", frame_bus.looped_sticky, want.looped_sticky);
		frames_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_r = SAMPLE_FORMAT_RESET;
			chan_r = CHANNEL_COUNT_RESET;
			frames_r = FRAMES_IN_DATA_RESET;
			gather = '0;
			gather_count = '0;
			slot = 1'b0;
			held = '0;
			position = '0;
			looped = 1'b0;
			frames_seen = 0;
			expected_frames.delete();
			outstanding <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_SAMPLE_FORMAT: fmt_r = cfg_wdata[2:0];
					CFG_CHANNEL_COUNT: chan_r = cfg_wdata[1:0];
					CFG_FRAMES_IN_DATA: frames_r = cfg_wdata[31:0];
					default: ;
				endcase
			end
			// check before predicting so a stray frame is never matched to a new one
			if (frame_bus.valid && frame_bus.ready)
				check_frame();
			if (byte_bus.valid && byte_bus.ready)
				absorb_byte(byte_bus.data_byte);
			outstanding <= expected_frames.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the WAVE sample to stereo 16-bit converter: clock, reset,
// configuration phases and byte stimulus with random stalls on both channels.
// Depends on wss_pkg, the channel interfaces, the block and wss_frame_checker.
`timescale 1ns / 1ps

module tb;
	import wss_pkg::*;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam int unsigned WATCHDOG_LIMIT = 4000;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_wdata;
	logic calm;
	int unsigned outstanding;
	int unsigned fail_count;
	int unsigned quiet_cycles;

	wss_byte_if byte_ch();
	wss_frame_if frame_ch();

	wave_sample_to_stereo16 u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.data(byte_ch),
		.frame(frame_ch)
	);

	wss_frame_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.byte_bus(byte_ch),
		.frame_bus(frame_ch),
		.outstanding(outstanding),
		.fail_count(fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		frame_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			frame_ch.ready <= calm || ($urandom_range(0, 99) >= 7);
		end
	end

	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((byte_ch.valid && byte_ch.ready) || (frame_ch.valid && frame_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while (!calm && $urandom_range(0, 99) < 7) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_word(input logic [31:0] w, input int unsigned nbytes);
		for (int i = 0; i < nbytes; i++)
			send_byte(w[8*i +: 8]);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic configure(input logic [2:0] fmt, input logic [1:0] ch, input logic [31:0] frames);
		write_reg(CFG_SAMPLE_FORMAT, 32'(fmt));
		write_reg(CFG_CHANNEL_COUNT, 32'(ch));
		write_reg(CFG_FRAMES_IN_DATA, frames);
		cfg_wr_en <= 1'b0;
	endtask

	// drop valid, wait for every predicted frame, then let the pipeline empty
	task automatic settle();
		byte_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] random_float();
		logic [7:0] e;
		case ($urandom_range(0, 9))
			0: e = 8'h00;
			1: e = 8'hFF;
			2, 3: e = 8'($urandom);
			default: e = 8'($urandom_range(105, 152));
		endcase
		return {1'($urandom), e, 23'($urandom)};
	endfunction

	initial begin
		logic [2:0] fmt;
		logic [1:0] ch;
		logic [31:0] frames;
		int unsigned target;
		int unsigned sent;

		calm = 1'b0;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= CFG_SAMPLE_FORMAT;
		cfg_wdata <= '0;
		byte_ch.valid <= 1'b0;
		byte_ch.data_byte <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pcm8 extremes, mono, wrapping every third frame
		configure(FMT_PCM8, CHANNELS_MONO, 32'd3);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(8'h7F);
		settle();

		// float NaN, negative infinity, -1.0 and a denormal; wrap on every frame
		configure(FMT_FLOAT32, CHANNELS_MONO, 32'd0);
		send_word(32'h7FC0_0001, 4);
		send_word(32'hFF80_0000, 4);
		send_word(32'hBF80_0000, 4);
		send_word(32'h0000_0001, 4);
		settle();

		// shrink the sample size with two bytes of a pcm32 sample gathered
		configure(FMT_PCM32, CHANNELS_STEREO, 32'hFFFF_FFFF);
		send_byte(8'hA5);
		send_byte(8'h5A);
		settle();
		configure(FMT_PCM16, CHANNELS_STEREO, 32'hFFFF_FFFF);
		send_word(32'h0000_C3FF, 2);
		send_word(32'h0000_8001, 2);
		send_byte(8'h12);
		send_byte(8'h34);
		settle();

		// switch to mono with a left sample held
		configure(FMT_PCM16, CHANNELS_MONO, 32'd2);
		send_word(32'h0000_7FFF, 2);
		settle();

		for (int ph = 0; ph < 14; ph++) begin
			calm = (ph == 5);
			fmt = (ph < 8) ? 3'(ph) : 3'($urandom_range(0, 7));
			if (ph < 4)
				ch = 2'(ph);
			else if ($urandom_range(0, 3) == 0)
				ch = $urandom_range(0, 1) ? 2'd0 : 2'd3;
			else
				ch = 2'($urandom_range(1, 2));
			case ($urandom_range(0, 4))
				0: frames = 32'd0;
				1: frames = 32'd1;
				2: frames = 32'($urandom_range(2, 6));
				3: frames = 32'hFFFF_FFFF;
				default: frames = $urandom;
			endcase
			if (ph == 0)
				frames = 32'd0;
			if (ph == 1)
				frames = 32'hFFFF_FFFF;
			if (ph == 3)
				write_reg(CFG_UNUSED, $urandom);
			configure(fmt, ch, frames);
			target = $urandom_range(30, 60);
			sent = 0;
			while (sent < target) begin
				if (fmt == FMT_FLOAT32) begin
					send_word(random_float(), 4);
					sent += 4;
				end else begin
					send_byte(8'($urandom));
					sent++;
				end
			end
			settle();
		end

		if (fail_count == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/wss_pkg.sv
rtl/core/wss_byte_if.sv
rtl/core/wss_frame_if.sv
rtl/core/wss_gather.sv
rtl/core/wss_convert.sv
rtl/core/wss_frame.sv
rtl/core/wave_sample_to_stereo16.sv
bench/wss_frame_checker.sv
bench/tb.sv
